FILE: rtl/hng_pkg.sv
// Package for the 5-smooth number generator: field widths, factor codes
// and the control and result structs of the shared scale-and-compare unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hng_pkg;

    // Fixed widths of the query and the result fields.
    localparam int INDEX_W = 12;
    localparam int VALUE_W = 63;

    // Factor codes for the shared unit.
    localparam logic [1:0] FACTOR_TWO   = 2'd0;
    localparam logic [1:0] FACTOR_THREE = 2'd1;
    localparam logic [1:0] FACTOR_FIVE  = 2'd2;

    typedef logic [VALUE_W-1:0] value_t;

    // Control from the sequencer to the shared unit.
    typedef struct packed {
        logic [1:0] factor;  // which factor scales the table entry
        logic       first;   // first candidate of a new entry: restart the minimum
    } unit_ctrl_t;

    // Results of the shared unit.
    typedef struct packed {
        value_t product;     // factor times the table entry, kept to the value width
        value_t least;       // running minimum including this product
    } unit_res_t;

endpackage : hng_pkg

`default_nettype wire

FILE: rtl/hng_scale_min.sv
// Shared arithmetic unit: scales a table entry by 2, 3 or 5 with a shift
// and, for 3 and 5, an add, and folds the product into the running minimum.
// Depends on hng_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hng_scale_min (
    input  wire hng_pkg::unit_ctrl_t ctrl,
    input  wire hng_pkg::value_t     entry,
    input  wire hng_pkg::value_t     least_in,
    output hng_pkg::unit_res_t       res
);
    import hng_pkg::*;

    value_t scaled;

    // Multiply by a small constant through a shift and at most one add.
    always_comb
    begin
        case (ctrl.factor)
            FACTOR_TWO:   scaled = {entry[VALUE_W-2:0], 1'b0};
            FACTOR_THREE: scaled = {entry[VALUE_W-2:0], 1'b0} + entry;
            FACTOR_FIVE:  scaled = {entry[VALUE_W-3:0], 2'b00} + entry;
            default:      scaled = '0;
        endcase
    end

    // Fold the product into the running minimum.
    always_comb
    begin
        res.product = scaled;
        if (ctrl.first || (scaled < least_in))
        begin
            res.least = scaled;
        end
        else
        begin
            res.least = least_in;
        end
    end

endmodule : hng_scale_min

`default_nettype wire

FILE: rtl/hamming_number_generator_core.sv
// Top level of the 5-smooth number generator: sequencer, table memory,
// pointers and output register. Depends on hng_pkg and hng_scale_min.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   query   | in_valid, in_ready, query_index[11:0]     | in
//   result  | out_valid, out_ready, number_value[62:0], | out
//           | out_of_range                              |
//
// An index in the table passes through LOOK and DONE, an out-of-range index
// straight to DONE. Generating an entry adds RD2, RD3, RD5, SC5 and WR:
// three reads of the single table read port, one scaling step of the shared
// unit per factor, and a write. After reset the table holds only entry one,
// with no clearing pass. A new query is taken only in the idle state, which
// can be reached while the previous result still waits in the output register;
// a finished result waits in place until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module hamming_number_generator_core #(
    parameter int TABLE_DEPTH = 2048
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire  [hng_pkg::INDEX_W-1:0] query_index,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [hng_pkg::VALUE_W-1:0] number_value,
    output logic                        out_of_range
);
    import hng_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(TABLE_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD2  = 3'd1;
    localparam logic [2:0] S_RD3  = 3'd2;
    localparam logic [2:0] S_RD5  = 3'd3;
    localparam logic [2:0] S_SC5  = 3'd4;
    localparam logic [2:0] S_WR   = 3'd5;
    localparam logic [2:0] S_LOOK = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] filled_reg, filled_next;
    logic [PW-1:0] ptr2_reg, ptr2_next;
    logic [PW-1:0] ptr3_reg, ptr3_next;
    logic [PW-1:0] ptr5_reg, ptr5_next;
    logic [PW-1:0] query_reg, query_next;
    logic          err_reg, err_next;
    value_t        least_reg, least_next;
    value_t        cand2_reg, cand2_next;
    value_t        cand3_reg, cand3_next;
    value_t        cand5_reg, cand5_next;
    logic          out_valid_reg;
    value_t        out_value_reg;
    logic          out_err_reg;

    value_t        table_mem [TABLE_DEPTH];
    value_t        rd_data_reg;
    logic          rd_one_reg;
    logic          rd_en;
    logic [PW-1:0] rd_pos;
    logic          wr_en;
    value_t        entry;

    unit_ctrl_t    unit_ctrl;
    unit_res_t     unit_res;

    logic          in_xfer;
    logic          out_free;
    logic          in_bounds;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_bounds = (query_index != '0) && (query_index <= INDEX_W'(TABLE_DEPTH));

    // Entry one is the constant 1; all others come from the memory.
    assign entry = rd_one_reg ? value_t'(1) : rd_data_reg;

    // Read position by state.
    always_comb
    begin
        rd_en  = 1'b0;
        rd_pos = query_reg;
        unique case (state_reg)
            S_RD2:
            begin
                rd_en  = 1'b1;
                rd_pos = ptr2_reg;
            end
            S_RD3:
            begin
                rd_en  = 1'b1;
                rd_pos = ptr3_reg;
            end
            S_RD5:
            begin
                rd_en  = 1'b1;
                rd_pos = ptr5_reg;
            end
            S_LOOK:
            begin
                rd_en  = 1'b1;
                rd_pos = query_reg;
            end
            default:
            begin
                rd_en  = 1'b0;
                rd_pos = query_reg;
            end
        endcase
    end

    assign wr_en = (state_reg == S_WR);

    // Table memory: one write port, one registered read port, positions from 1.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[AW'(filled_reg)] <= least_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[AW'(rd_pos - PW'(1))];
            rd_one_reg  <= (rd_pos == PW'(1));
        end
    end

    // Shared unit control: the data read in the previous state is scaled.
    always_comb
    begin
        unit_ctrl.first  = (state_reg == S_RD3);
        unit_ctrl.factor = FACTOR_TWO;
        if (state_reg == S_RD5)
        begin
            unit_ctrl.factor = FACTOR_THREE;
        end
        else if (state_reg == S_SC5)
        begin
            unit_ctrl.factor = FACTOR_FIVE;
        end
    end

    hng_scale_min u_scale_min (
        .ctrl     (unit_ctrl),
        .entry    (entry),
        .least_in (least_reg),
        .res      (unit_res)
    );

    // Sequencer next-state and datapath updates.
    always_comb
    begin
        state_next  = state_reg;
        filled_next = filled_reg;
        ptr2_next   = ptr2_reg;
        ptr3_next   = ptr3_reg;
        ptr5_next   = ptr5_reg;
        query_next  = query_reg;
        err_next    = err_reg;
        least_next  = least_reg;
        cand2_next  = cand2_reg;
        cand3_next  = cand3_reg;
        cand5_next  = cand5_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    query_next = query_index[PW-1:0];
                    err_next   = !in_bounds;
                    if (!in_bounds)
                    begin
                        state_next = S_DONE;
                    end
                    else if (query_index <= INDEX_W'(filled_reg))
                    begin
                        state_next = S_LOOK;
                    end
                    else
                    begin
                        state_next = S_RD2;
                    end
                end
            end
            S_RD2:
            begin
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cand2_next = unit_res.product;
                least_next = unit_res.least;
                state_next = S_RD5;
            end
            S_RD5:
            begin
                cand3_next = unit_res.product;
                least_next = unit_res.least;
                state_next = S_SC5;
            end
            S_SC5:
            begin
                cand5_next = unit_res.product;
                least_next = unit_res.least;
                state_next = S_WR;
            end
            S_WR:
            begin
                // Each pointer moves past the candidate that equals the new entry.
                filled_next = filled_reg + PW'(1);
                if (cand2_reg == least_reg)
                begin
                    ptr2_next = ptr2_reg + PW'(1);
                end
                if (cand3_reg == least_reg)
                begin
                    ptr3_next = ptr3_reg + PW'(1);
                end
                if (cand5_reg == least_reg)
                begin
                    ptr5_next = ptr5_reg + PW'(1);
                end
                if (filled_next < query_reg)
                begin
                    state_next = S_RD2;
                end
                else
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            filled_reg <= PW'(1);
            ptr2_reg   <= PW'(1);
            ptr3_reg   <= PW'(1);
            ptr5_reg   <= PW'(1);
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            ptr2_reg   <= ptr2_next;
            ptr3_reg   <= ptr3_next;
            ptr5_reg   <= ptr5_next;
        end
    end

    // Working registers of the current query.
    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
        err_reg   <= err_next;
        least_reg <= least_next;
        cand2_reg <= cand2_next;
        cand3_reg <= cand3_next;
        cand5_reg <= cand5_next;
    end

    // Output register: loaded from the done state when free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_value_reg <= err_reg ? '0 : entry;
            out_err_reg   <= err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign number_value = out_value_reg;
    assign out_of_range = out_err_reg;

`ifndef NO_ASSERTIONS
    // No pointer runs past the filled part of the table.
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ptr2_reg <= filled_reg) && (ptr3_reg <= filled_reg) && (ptr5_reg <= filled_reg))
        else $error("pointer beyond filled count");

    // Each write grows the filled count by exactly one.
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR) |=> (filled_reg == PW'($past(filled_reg) + PW'(1))))
        else $error("filled count did not step by one");

    // An out-of-range result carries a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (number_value == '0))
        else $error("out-of-range result with nonzero value");

    // The filled count never exceeds the table depth.
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= PW'(TABLE_DEPTH))
        else $error("filled count beyond table depth");
`endif

endmodule : hamming_number_generator_core

`default_nettype wire
